/* rtl/ffha_pkg.sv */
// Package for the first-fit heap allocator: item types and command/status structs.
// No dependencies; used by every module in rtl/.
`default_nettype none
package ffha_pkg;

   typedef struct packed {
      logic        action;
      logic [7:0]  request_bytes;
      logic        pointer_present;
      logic [11:0] block_offset;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [11:0] payload_offset;
      logic [12:0] remaining_bytes;
   } rsp_type;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Datapath operations issued by the controller.
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;
   localparam logic [3:0] OP_RD_CURR   = 4'd2;
   localparam logic [3:0] OP_STEP      = 4'd3;
   localparam logic [3:0] OP_A_UNLINK  = 4'd4;
   localparam logic [3:0] OP_A_SPLIT   = 4'd5;
   localparam logic [3:0] OP_A_DONE    = 4'd6;
   localparam logic [3:0] OP_F_CHECK   = 4'd7;
   localparam logic [3:0] OP_F_LINK    = 4'd8;
   localparam logic [3:0] OP_F_RDNEXT  = 4'd9;
   localparam logic [3:0] OP_F_MERGE   = 4'd10;
   localparam logic [3:0] OP_REJECT    = 4'd11;
   localparam logic [3:0] OP_F_DONE    = 4'd12;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic early_reject;   // alloc: zero/too big; free: bad pointer
      logic walk_done;      // walk loop ends this cycle
      logic alloc_fail;     // alloc: no fitting block at end of walk
      logic free_bad;       // free: block not allocated
   } sts_type;

endpackage
`default_nettype wire

/* rtl/ffha_datapath.sv */
// Datapath of the allocator: link and size memories, walk pointers, remaining count.
// Depends on ffha_pkg; driven by ffha_ctrl through cmd_type/sts_type.
`default_nettype none
module ffha_datapath
   import ffha_pkg::*;
#(
   parameter int HEAP_BYTES   = 4096,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_in,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output rsp_type      rsp_data
);

   localparam int HDR   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int NGRAN = HEAP_BYTES / ALIGN_BYTES;
   localparam int SENT  = (HEAP_BYTES - HDR) / ALIGN_BYTES;
   localparam int GW    = $clog2(NGRAN);          // granule index width
   localparam int LW    = GW + 1;                 // link width, null = NGRAN
   localparam int SW    = $clog2(HEAP_BYTES) + 1; // byte size width
   localparam int AS    = $clog2(ALIGN_BYTES);
   localparam int CW    = $clog2(NGRAN) + 1;      // step counter width
   localparam logic [LW-1:0] NIL    = LW'(NGRAN);
   localparam logic [LW-1:0] SENT_L = LW'(SENT);
   localparam logic [SW-1:0] HDR_S  = SW'(HDR);

   // Memories: one read and one write per cycle each.
   logic [LW-1:0] link_mem [NGRAN];
   logic [SW-1:0] size_mem [NGRAN];
   logic [LW-1:0] link_rd_ff;
   logic [SW-1:0] size_rd_ff;
   logic [GW-1:0] rd_addr;

   logic [LW-1:0] head_ff, head_in;
   logic [SW-1:0] remain_ff, remain_in;
   logic          init_ff;     // sentinel write pending after reset
   logic [LW-1:0] prev_ff, prev_in, curr_ff, curr_in;
   logic          prev_head_ff, prev_head_in;
   logic [SW-1:0] need_ff, need_in;
   logic [SW-1:0] psize_ff, psize_in;  // size of prev block (free)
   logic [LW-1:0] plink_ff, plink_in;  // link of prev (or head)
   logic [SW-1:0] gsize_ff, gsize_in;  // size of target block
   logic [LW-1:0] blk_ff, blk_in;
   logic [SW-1:0] bsize_ff, bsize_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [LW-1:0] g_ff, g_in;
   rsp_type       rsp_ff, rsp_in;

   logic          lw_en, sw_en;
   logic [GW-1:0] lw_addr, sw_addr;
   logic [LW-1:0] lw_data;
   logic [SW-1:0] sw_data;

   logic [SW-1:0] need_calc;
   logic [SW-1:0] hbytes;
   logic [LW-1:0] nw;
   logic [SW-1:0] leftover;
   logic [SW+1:0] rsum;

   // Rounded allocation size: payload plus header, up to the alignment.
   always_comb begin
      logic [SW:0] t;
      t = (SW+1)'(req_in.request_bytes) + (SW+1)'(HDR) + (SW+1)'(ALIGN_BYTES - 1);
      need_calc = SW'((t >> AS) << AS);
      hbytes = SW'(req_in.block_offset) - HDR_S;
   end

   // Early checks on a fresh request, then walk termination and failure
   // using the entry of curr just read.
   always_comb begin
      sts.is_free = req_in.action == ACT_FREE;
      if (req_in.action == ACT_ALLOC) begin
         sts.early_reject = req_in.request_bytes == 8'd0 || need_calc > remain_ff;
      end else begin
         sts.early_reject = !req_in.pointer_present || SW'(req_in.block_offset) < HDR_S ||
            hbytes[AS-1:0] != '0 || (SW'(req_in.block_offset) - HDR_S) >= SW'(SENT * ALIGN_BYTES);
      end
      if (need_ff != '0) begin
         sts.walk_done = curr_ff >= NIL || size_rd_ff >= need_ff || link_rd_ff >= NIL ||
            steps_ff >= CW'(NGRAN);
      end else begin
         sts.walk_done = curr_ff >= NIL || curr_ff >= g_ff || steps_ff >= CW'(NGRAN);
      end
      sts.alloc_fail = curr_ff >= NIL || curr_ff == SENT_L || size_rd_ff < need_ff;
      sts.free_bad   = link_rd_ff < NIL || init_ff;
   end

   assign nw       = curr_ff + LW'(need_ff >> AS);
   assign leftover = size_rd_ff - need_ff;
   assign rsum     = (SW+2)'(remain_ff) + (SW+2)'(gsize_ff);

   // Next-state logic of the datapath registers and memory ports.
   always_comb begin
      head_in = head_ff; remain_in = remain_ff; prev_in = prev_ff; curr_in = curr_ff;
      prev_head_in = prev_head_ff; need_in = need_ff; psize_in = psize_ff;
      plink_in = plink_ff; gsize_in = gsize_ff; blk_in = blk_ff; bsize_in = bsize_ff;
      steps_in = steps_ff; g_in = g_ff; rsp_in = rsp_ff;
      lw_en = 1'b0; sw_en = 1'b0; lw_addr = '0; sw_addr = '0; lw_data = '0; sw_data = '0;
      rd_addr = curr_ff[GW-1:0];
      unique case (cmd.op)
         OP_LOAD: begin
            prev_head_in = 1'b1; prev_in = NIL; curr_in = head_ff; steps_in = '0;
            plink_in = head_ff;
            if (req_in.action == ACT_ALLOC) begin
               need_in = need_calc; g_in = NIL;
               rd_addr = head_ff[GW-1:0];
            end else begin
               need_in = '0; g_in = LW'(hbytes >> AS);
               rd_addr = GW'(hbytes >> AS);
            end
         end
         OP_RD_CURR: begin
            rd_addr = curr_ff[GW-1:0];
         end
         OP_F_CHECK: begin
            // Target entry is in the read registers; now start the walk at head.
            gsize_in = init_ff ? '0 : size_rd_ff;
            rd_addr = curr_ff[GW-1:0];
         end
         OP_STEP: begin
            prev_in = curr_ff; prev_head_in = 1'b0; psize_in = size_rd_ff;
            plink_in = link_rd_ff; curr_in = link_rd_ff; steps_in = steps_ff + 1'b1;
            rd_addr = link_rd_ff[GW-1:0];
         end
         OP_A_UNLINK: begin
            // prev.link = curr.link, or the split-off tail when the block is split.
            if (leftover > SW'(2 * HDR) && nw < NIL) plink_in = nw;
            else plink_in = link_rd_ff;
            if (prev_head_ff) head_in = plink_in;
            else begin lw_en = 1'b1; lw_addr = prev_ff[GW-1:0]; lw_data = plink_in; end
            bsize_in = size_rd_ff;
         end
         OP_A_SPLIT: begin
            lw_en = 1'b1; lw_addr = curr_ff[GW-1:0]; lw_data = NIL;
            if (leftover > SW'(2 * HDR) && nw < NIL) begin
               sw_en = 1'b1; sw_addr = nw[GW-1:0]; sw_data = leftover;
               bsize_in = need_ff;
            end
         end
         OP_A_DONE: begin
            // Finish split writes: curr size and new block link.
            if (bsize_ff == need_ff && leftover > SW'(2 * HDR) && nw < NIL) begin
               sw_en = 1'b1; sw_addr = curr_ff[GW-1:0]; sw_data = need_ff;
               lw_en = 1'b1; lw_addr = nw[GW-1:0]; lw_data = link_rd_ff;
            end
            remain_in = bsize_ff >= remain_ff ? '0 : remain_ff - bsize_ff;
            rsp_in.granted = 1'b1;
            rsp_in.payload_offset = 12'((curr_ff[GW-1:0] << AS) + HDR);
            rsp_in.remaining_bytes = 13'(remain_in);
         end
         OP_F_LINK: begin
            remain_in = rsum > (SW+2)'(HEAP_BYTES) ? SW'(HEAP_BYTES) : SW'(rsum);
            if (!prev_head_ff && (SW+1)'(prev_ff[GW-1:0]) * (SW+1)'(ALIGN_BYTES)
                  + (SW+1)'(psize_ff) == (SW+1)'(g_ff) * (SW+1)'(ALIGN_BYTES)) begin
               bsize_in = psize_ff + gsize_ff; blk_in = prev_ff; plink_in = plink_ff;
               sw_en = 1'b1; sw_addr = prev_ff[GW-1:0]; sw_data = bsize_in;
            end else begin
               lw_en = 1'b1; lw_addr = g_ff[GW-1:0]; lw_data = plink_ff;
               if (prev_head_ff) head_in = g_ff;
               else begin
                  // prev link write goes next cycle through blk path
               end
               blk_in = g_ff; bsize_in = gsize_ff;
            end
         end
         OP_F_RDNEXT: begin
            if (blk_ff == g_ff && !prev_head_ff) begin
               lw_en = 1'b1; lw_addr = prev_ff[GW-1:0]; lw_data = g_ff;
            end
            rd_addr = plink_ff[GW-1:0];
         end
         OP_F_MERGE: begin
            if (plink_ff < NIL && plink_ff != SENT_L &&
                (SW+1)'(blk_ff[GW-1:0]) * (SW+1)'(ALIGN_BYTES) + (SW+1)'(bsize_ff)
                   == (SW+1)'(plink_ff) * (SW+1)'(ALIGN_BYTES)) begin
               sw_en = 1'b1; sw_addr = blk_ff[GW-1:0]; sw_data = bsize_ff + size_rd_ff;
               lw_en = 1'b1; lw_addr = blk_ff[GW-1:0]; lw_data = link_rd_ff;
            end
         end
         OP_F_DONE: begin
            rsp_in.granted = 1'b1; rsp_in.payload_offset = '0;
            rsp_in.remaining_bytes = 13'(remain_ff);
         end
         OP_REJECT: begin
            rsp_in.granted = 1'b0; rsp_in.payload_offset = '0;
            rsp_in.remaining_bytes = 13'(remain_ff);
         end
         default: begin
         end
      endcase
      if (reset) begin
         // Reset image: granule zero spans the heap below the sentinel.
         lw_en = 1'b1; lw_addr = '0; lw_data = SENT_L;
         sw_en = 1'b1; sw_addr = '0; sw_data = SW'(SENT * ALIGN_BYTES);
      end else if (init_ff) begin
         // The sentinel is an empty block with a null link.
         lw_en = 1'b1; lw_addr = SENT_L[GW-1:0]; lw_data = NIL;
         sw_en = 1'b1; sw_addr = SENT_L[GW-1:0]; sw_data = '0;
      end
   end

   // Memory ports.
   always_ff @(posedge clock) begin
      if (lw_en) link_mem[lw_addr] <= lw_data;
      if (sw_en) size_mem[sw_addr] <= sw_data;
      link_rd_ff <= link_mem[rd_addr];
      size_rd_ff <= size_mem[rd_addr];
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0; remain_ff <= SW'(SENT * ALIGN_BYTES); init_ff <= 1'b1;
         rsp_ff <= '0; steps_ff <= '0;
      end else begin
         head_ff <= head_in; remain_ff <= remain_in; init_ff <= 1'b0; rsp_ff <= rsp_in;
         steps_ff <= steps_in;
      end
      prev_ff <= prev_in; curr_ff <= curr_in; prev_head_ff <= prev_head_in;
      need_ff <= need_in; psize_ff <= psize_in; plink_ff <= plink_in; gsize_ff <= gsize_in;
      blk_ff <= blk_in; bsize_ff <= bsize_in; g_ff <= g_in;
   end

   assign rsp_data = rsp_ff;

   // The remaining count never exceeds the heap.
   assert property (@(posedge clock) disable iff (reset) remain_ff <= SW'(HEAP_BYTES))
      else $error("remaining count above heap size");
   // A walk never runs past the granule count.
   assert property (@(posedge clock) disable iff (reset) steps_ff <= CW'(NGRAN))
      else $error("walk step counter overflow");
   // A granted allocate always lowers or keeps the remaining count.
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_A_DONE |=> remain_ff <= $past(remain_ff))
      else $error("allocate raised the remaining count");

endmodule
`default_nettype wire

/* rtl/ffha_ctrl.sv */
// Controller state machine of the allocator: sequences walks, splits and merges.
// Depends on ffha_pkg; commands ffha_datapath.
`default_nettype none
module ffha_ctrl
   import ffha_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy,
   output logic         done
);

   localparam logic [3:0] S_IDLE = 4'd0, S_AWALK = 4'd1, S_AUNL = 4'd2, S_ASPL = 4'd3,
      S_ADONE = 4'd4, S_FCHK = 4'd5, S_FWAIT = 4'd6, S_FWALK = 4'd7, S_FLINK = 4'd8,
      S_FRDN = 4'd9, S_FMRG = 4'd10, S_FDONE = 4'd11, S_REJ = 4'd12, S_OUT = 4'd13;

   logic [3:0] state_ff, state_in;

   // Next state and command.
   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      unique case (state_ff)
         S_IDLE: if (start) begin
            if (sts.early_reject) begin cmd.op = OP_REJECT; state_in = S_OUT; end
            else begin
               cmd.op = OP_LOAD;
               state_in = sts.is_free ? S_FCHK : S_AWALK;
            end
         end
         S_AWALK: begin
            if (sts.walk_done) state_in = sts.alloc_fail ? S_REJ : S_AUNL;
            else cmd.op = OP_STEP;
         end
         S_AUNL: begin cmd.op = OP_A_UNLINK; state_in = S_ASPL; end
         S_ASPL: begin cmd.op = OP_A_SPLIT; state_in = S_ADONE; end
         S_ADONE: begin cmd.op = OP_A_DONE; state_in = S_OUT; end
         S_FCHK: begin
            if (sts.free_bad) state_in = S_REJ;
            else begin cmd.op = OP_F_CHECK; state_in = S_FWAIT; end
         end
         S_FWAIT: begin cmd.op = OP_RD_CURR; state_in = S_FWALK; end
         S_FWALK: begin
            if (sts.walk_done) state_in = S_FLINK;
            else cmd.op = OP_STEP;
         end
         S_FLINK: begin cmd.op = OP_F_LINK; state_in = S_FRDN; end
         S_FRDN: begin cmd.op = OP_F_RDNEXT; state_in = S_FMRG; end
         S_FMRG: begin cmd.op = OP_F_MERGE; state_in = S_FDONE; end
         S_FDONE: begin cmd.op = OP_F_DONE; state_in = S_OUT; end
         S_REJ: begin cmd.op = OP_REJECT; state_in = S_OUT; end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = state_ff != S_IDLE;
   assign done = state_ff == S_OUT;

   // A result strobe follows a finishing state, or the idle state for an early reject.
   assert property (@(posedge clock) disable iff (reset)
      done |-> $past(state_ff) == S_ADONE || $past(state_ff) == S_FDONE ||
               $past(state_ff) == S_REJ || $past(state_ff) == S_IDLE)
      else $error("result without finishing step");
   // Start while idle always leaves idle.
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("start ignored");
   // The strobe lasts one cycle.
   assert property (@(posedge clock) disable iff (reset) done |=> !done)
      else $error("result strobe stretched");

endmodule
`default_nettype wire

/* rtl/first_fit_heap_allocator_top.sv */
// Top level of the first-fit heap allocator: controller plus datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_datapath.
// Sequence: an item rejected on its fields goes straight to the result; a free of a block
//   that is not allocated passes the check and reject steps; an allocate walks one step per
//   free block, then rejects, or unlinks, splits and finishes; a free checks, walks the free
//   blocks below it, links, reads the next block, merges and finishes; one memory read per step.
// Throughput: one item at a time; start is taken only while busy is low.
// Reset: synchronous; the heap is one free block and the sentinel, ready at once.
`default_nettype none
module first_fit_heap_allocator_top
   import ffha_pkg::*;
#(
   parameter int HEAP_BYTES   = 4096,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;
   req_type req_ff;
   req_type req_sel;

   // Hold the item for the whole operation.
   always_ff @(posedge clock) begin
      if (start && !busy) req_ff <= req_data;
   end
   assign req_sel = busy ? req_ff : req_data;

   ffha_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .cmd(cmd),
      .busy(busy), .done(rsp_valid)
   );

   ffha_datapath #(
      .HEAP_BYTES(HEAP_BYTES), .ALIGN_BYTES(ALIGN_BYTES), .HEADER_BYTES(HEADER_BYTES)
   ) u_dp (
      .clock(clock), .reset(reset), .req_in(req_sel), .cmd(cmd), .sts(sts),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire
